FILE: sv/llpm_pkg.sv
// Package for the linked list pool manager: sizes, request and status codes,
// controller states and the command/flag structs between controller and datapath.
// No dependencies.
`default_nettype none

package llpm_pkg;

  localparam int NumNodes = 64;
  localparam int NumLists = 4;
  localparam int NodeW    = 6;
  localparam int LinkW    = NodeW + 1;
  localparam int ListW    = 2;
  localparam int OwnW     = ListW + 1;
  localparam int CountW   = 7;
  localparam int InW      = 24;
  localparam int OutW     = 24;

  localparam logic [LinkW-1:0] NoNode = LinkW'(NumNodes);
  localparam logic [OwnW-1:0]  NoList = OwnW'(NumLists);

  typedef enum logic [1:0] {
    REQ_BUILD = 2'd0,
    REQ_MOVE  = 2'd1,
    REQ_ALLOC = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SAME  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_UNLINK,
    S_LINK1,
    S_LINK2,
    S_BUILD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic ready;
    logic latch;
    logic dec;
    logic unlink;
    logic link1;
    logic link2;
    logic build;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic build_go;
    logic move_go;
    logic unlink_ok;
    logic build_last;
    logic out_free;
  } flag_t;

  function automatic logic is_node(input logic [LinkW-1:0] link);
    return link < NoNode;
  endfunction

endpackage

`default_nettype wire

FILE: sv/llpm_ctrl.sv
// Controller state machine for the linked list pool manager.
// Depends on llpm_pkg; drives the datapath through cmd_t, reads flag_t.
`default_nettype none

module llpm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  input  wire llpm_pkg::flag_t flag,
  output llpm_pkg::cmd_t      cmd
);

  llpm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llpm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      llpm_pkg::S_IDLE: begin
        if (s_tvalid) state_next = llpm_pkg::S_DEC;
      end
      llpm_pkg::S_DEC: begin
        if (flag.build_go) begin
          state_next = llpm_pkg::S_BUILD;
        end else if (flag.move_go) begin
          state_next = llpm_pkg::S_UNLINK;
        end else begin
          state_next = llpm_pkg::S_DONE;
        end
      end
      llpm_pkg::S_UNLINK: begin
        state_next = flag.unlink_ok ? llpm_pkg::S_LINK1 : llpm_pkg::S_DONE;
      end
      llpm_pkg::S_LINK1: state_next = llpm_pkg::S_LINK2;
      llpm_pkg::S_LINK2: state_next = llpm_pkg::S_DONE;
      llpm_pkg::S_BUILD: begin
        if (flag.build_last) state_next = llpm_pkg::S_DONE;
      end
      llpm_pkg::S_DONE: begin
        if (flag.out_free) state_next = llpm_pkg::S_IDLE;
      end
      default: state_next = llpm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.ready  = (state == llpm_pkg::S_IDLE);
    cmd.latch  = (state == llpm_pkg::S_IDLE) && s_tvalid;
    cmd.dec    = (state == llpm_pkg::S_DEC);
    cmd.unlink = (state == llpm_pkg::S_UNLINK);
    cmd.link1  = (state == llpm_pkg::S_LINK1);
    cmd.link2  = (state == llpm_pkg::S_LINK2);
    cmd.build  = (state == llpm_pkg::S_BUILD);
    cmd.finish = (state == llpm_pkg::S_DONE);
  end

endmodule

`default_nettype wire

FILE: sv/llpm_datapath.sv
// Datapath for the linked list pool manager: link and owner memories,
// list head/tail registers, request registers and the output register.
// Depends on llpm_pkg; driven by llpm_ctrl through cmd_t.
`default_nettype none

module llpm_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [llpm_pkg::InW-1:0]   s_tdata,
  input  wire llpm_pkg::cmd_t             cmd,
  output llpm_pkg::flag_t                 flag,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [llpm_pkg::OutW-1:0]       m_tdata
);

  localparam int NodeW = llpm_pkg::NodeW;
  localparam int LinkW = llpm_pkg::LinkW;
  localparam int ListW = llpm_pkg::ListW;
  localparam int OwnW  = llpm_pkg::OwnW;
  localparam int CountW = llpm_pkg::CountW;

  // request registers
  llpm_pkg::req_t    req_r;
  llpm_pkg::status_t stat_r;
  logic [ListW-1:0]  list_r;
  logic [ListW-1:0]  src_r;
  logic [NodeW-1:0]  node_r;
  logic [NodeW-1:0]  res_r;
  logic [CountW-1:0] cnt_r;
  logic              back_r;

  // build walk
  logic [NodeW-1:0]  cur_r;
  logic [CountW-1:0] rem_r;
  logic              first_r;

  // storage
  logic [LinkW-1:0] next_mem  [llpm_pkg::NumNodes];
  logic [LinkW-1:0] prev_mem  [llpm_pkg::NumNodes];
  logic [OwnW-1:0]  owner_mem [llpm_pkg::NumNodes];
  logic [llpm_pkg::NumNodes-1:0] owner_vld;
  logic [LinkW-1:0] head_of_list [llpm_pkg::NumLists];
  logic [LinkW-1:0] tail_of_list [llpm_pkg::NumLists];

  // read side
  logic [NodeW-1:0] rd_addr;
  logic [LinkW-1:0] nx_q, p_q;
  logic [OwnW-1:0]  own_q;
  logic             vld_q;

  // write side
  logic             nx_we, pv_we, ow_we;
  logic [NodeW-1:0] nx_wa, pv_wa, ow_wa;
  logic [LinkW-1:0] nx_wd, pv_wd;

  logic [LinkW-1:0] src_head, dst_head, dst_tail, node_link, cur_link;
  logic [OwnW-1:0]  own_eff;
  logic [ListW-1:0] own_idx;
  logic             dst_ok, src_ok, own_bad, own_same, build_bad, unlink_ok;
  logic [CountW:0]  build_sum;
  logic [LinkW-1:0] out_first, out_last;

  assign src_head  = head_of_list[src_r];
  assign dst_head  = head_of_list[list_r];
  assign dst_tail  = tail_of_list[list_r];
  assign node_link = {1'b0, node_r};
  assign cur_link  = {1'b0, cur_r};
  assign dst_ok    = {1'b0, list_r} < llpm_pkg::NoList;
  assign src_ok    = {1'b0, src_r} < llpm_pkg::NoList;
  assign build_sum = {2'b00, node_r} + {1'b0, cnt_r};
  assign build_bad = !dst_ok || (cnt_r == '0) ||
                     (build_sum > (CountW+1)'(llpm_pkg::NumNodes));
  assign own_eff   = vld_q ? own_q : llpm_pkg::NoList;
  assign own_idx   = own_eff[ListW-1:0];
  assign own_bad   = own_eff >= llpm_pkg::NoList;
  assign own_same  = own_eff == {1'b0, list_r};
  assign unlink_ok = !own_bad && !own_same;

  assign rd_addr = (cmd.dec && req_r == llpm_pkg::REQ_ALLOC) ?
                   src_head[NodeW-1:0] : node_r;

  always_comb begin
    flag            = '0;
    flag.build_go   = (req_r == llpm_pkg::REQ_BUILD) && !build_bad;
    flag.move_go    = ((req_r == llpm_pkg::REQ_MOVE) && dst_ok) ||
                      ((req_r == llpm_pkg::REQ_ALLOC) && dst_ok && src_ok &&
                       llpm_pkg::is_node(src_head));
    flag.unlink_ok  = unlink_ok;
    flag.build_last = (rem_r == CountW'(1));
    flag.out_free   = !m_tvalid || m_tready;
  end

  // memory reads
  always_ff @(posedge clk) begin
    nx_q  <= next_mem[rd_addr];
    p_q   <= prev_mem[rd_addr];
    own_q <= owner_mem[rd_addr];
    vld_q <= owner_vld[rd_addr];
  end

  // write port selection
  always_comb begin
    nx_we = 1'b0;
    nx_wa = node_r;
    nx_wd = llpm_pkg::NoNode;
    pv_we = 1'b0;
    pv_wa = node_r;
    pv_wd = llpm_pkg::NoNode;
    ow_we = 1'b0;
    ow_wa = node_r;
    if (cmd.unlink && unlink_ok) begin
      nx_we = llpm_pkg::is_node(p_q);
      nx_wa = p_q[NodeW-1:0];
      nx_wd = nx_q;
      pv_we = llpm_pkg::is_node(nx_q);
      pv_wa = nx_q[NodeW-1:0];
      pv_wd = p_q;
    end else if (cmd.link1) begin
      if (back_r) begin
        nx_we = llpm_pkg::is_node(dst_tail);
        nx_wa = dst_tail[NodeW-1:0];
        nx_wd = node_link;
        pv_we = 1'b1;
        pv_wd = llpm_pkg::is_node(dst_tail) ? dst_tail : llpm_pkg::NoNode;
      end else begin
        pv_we = llpm_pkg::is_node(dst_head);
        pv_wa = dst_head[NodeW-1:0];
        pv_wd = node_link;
        nx_we = 1'b1;
        nx_wd = llpm_pkg::is_node(dst_head) ? dst_head : llpm_pkg::NoNode;
      end
    end else if (cmd.link2) begin
      nx_we = back_r;
      pv_we = !back_r;
      ow_we = 1'b1;
    end else if (cmd.build) begin
      nx_we = 1'b1;
      nx_wa = cur_r;
      nx_wd = flag.build_last ? llpm_pkg::NoNode : cur_link + LinkW'(1);
      pv_we = 1'b1;
      pv_wa = cur_r;
      pv_wd = first_r ? llpm_pkg::NoNode : cur_link - LinkW'(1);
      ow_we = 1'b1;
      ow_wa = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (ow_we) owner_mem[ow_wa] <= {1'b0, list_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_vld <= '0;
    end else if (ow_we) begin
      owner_vld[ow_wa] <= 1'b1;
    end
  end

  // list heads and tails
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < llpm_pkg::NumLists; i++) begin
        head_of_list[i] <= llpm_pkg::NoNode;
        tail_of_list[i] <= llpm_pkg::NoNode;
      end
    end else begin
      if (cmd.unlink && unlink_ok) begin
        if (head_of_list[own_idx] == node_link) begin
          head_of_list[own_idx] <= llpm_pkg::is_node(nx_q) ? nx_q : llpm_pkg::NoNode;
        end
        if (tail_of_list[own_idx] == node_link) begin
          tail_of_list[own_idx] <= llpm_pkg::is_node(p_q) ? p_q : llpm_pkg::NoNode;
        end
      end
      if (cmd.link2) begin
        if (back_r) begin
          tail_of_list[list_r] <= node_link;
          if (!llpm_pkg::is_node(dst_head)) head_of_list[list_r] <= node_link;
        end else begin
          head_of_list[list_r] <= node_link;
          if (!llpm_pkg::is_node(dst_tail)) tail_of_list[list_r] <= node_link;
        end
      end
      if (cmd.build && flag.build_last) begin
        head_of_list[list_r] <= node_link;
        tail_of_list[list_r] <= cur_link;
      end
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= llpm_pkg::req_t'(s_tdata[1:0]);
      list_r <= s_tdata[3:2];
      src_r  <= s_tdata[5:4];
      node_r <= s_tdata[11:6];
      res_r  <= s_tdata[11:6];
      cnt_r  <= s_tdata[18:12];
      back_r <= s_tdata[19];
    end
    if (cmd.dec) begin
      case (req_r)
        llpm_pkg::REQ_BUILD: begin
          stat_r  <= build_bad ? llpm_pkg::ST_BAD : llpm_pkg::ST_DONE;
          cur_r   <= node_r;
          rem_r   <= cnt_r;
          first_r <= 1'b1;
        end
        llpm_pkg::REQ_MOVE: begin
          stat_r <= dst_ok ? llpm_pkg::ST_DONE : llpm_pkg::ST_BAD;
        end
        llpm_pkg::REQ_ALLOC: begin
          if (!dst_ok || !src_ok) begin
            stat_r <= llpm_pkg::ST_BAD;
            res_r  <= '0;
          end else if (!llpm_pkg::is_node(src_head)) begin
            stat_r <= llpm_pkg::ST_EMPTY;
            res_r  <= '0;
          end else begin
            stat_r <= llpm_pkg::ST_DONE;
            node_r <= src_head[NodeW-1:0];
            res_r  <= src_head[NodeW-1:0];
          end
        end
        default: stat_r <= llpm_pkg::ST_BAD;
      endcase
    end
    if (cmd.unlink) begin
      stat_r <= own_bad  ? llpm_pkg::ST_BAD :
                own_same ? llpm_pkg::ST_SAME : llpm_pkg::ST_DONE;
    end
    if (cmd.build) begin
      cur_r   <= cur_r + NodeW'(1);
      rem_r   <= rem_r - CountW'(1);
      first_r <= 1'b0;
    end
  end

  // output register
  assign out_first = (dst_ok && llpm_pkg::is_node(dst_head)) ? dst_head : llpm_pkg::NoNode;
  assign out_last  = (dst_ok && llpm_pkg::is_node(dst_tail)) ? dst_tail : llpm_pkg::NoNode;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish && flag.out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && flag.out_free) begin
      m_tdata <= {2'b00, out_last, out_first, res_r, stat_r};
    end
  end

endmodule

`default_nettype wire

FILE: sv/linked_list_pool_manager_top.sv
// Top level of the linked list pool manager: controller plus datapath.
// Steps: move/allocate go decode, unlink, link1, link2, done; build goes decode, then
// build for each node, then done; rejected requests leave decode or unlink for done.
// One item in flight: s_tready is high only in idle; done waits for a free output.
// Reset (rst, synchronous): lists empty, all nodes unowned, output empty; links undefined.
`default_nettype none

module linked_list_pool_manager_top (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // req_type[1:0], list_id[3:2], src_list[5:4], node_index[11:6],
  // node_count[18:12], at_back[19], zero[23:20]
  input  wire logic [llpm_pkg::InW-1:0] s_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // status[1:0], result_node[7:2], dest_first[14:8], dest_last[21:15], zero[23:22]
  output logic [llpm_pkg::OutW-1:0]     m_tdata
);

  llpm_pkg::cmd_t  cmd;
  llpm_pkg::flag_t flag;

  llpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .flag     (flag),
    .cmd      (cmd)
  );

  llpm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .flag     (flag),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  assign s_tready = cmd.ready;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another is in flight");

  a_one_write_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.unlink, cmd.link1, cmd.link2, cmd.build, cmd.dec, cmd.finish}))
    else $error("controller issued overlapping commands");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && flag.out_free |=> m_tvalid && s_tready)
    else $error("finished item not presented");

  a_link_after_unlink: assert property (@(posedge clk) disable iff (rst)
    cmd.link1 |-> $past(cmd.unlink) && $past(flag.unlink_ok))
    else $error("link step without a checked unlink");

endmodule

`default_nettype wire
